@@ rtl/idq_pkg.sv @@
// ----------------------------------------------------------------------------
// idq_pkg
// Types, widths and operation codes shared by the indexed deque and its cells.
// ----------------------------------------------------------------------------
package idq_pkg;

    // Number of storage cells in the row.
    localparam int DEPTH = 16;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // Fill counter must hold DEPTH itself.
    localparam int FILL_W  = $clog2(DEPTH + 1);
    // Common width for comparing positions against the fill level.
    localparam int IDX_W   = (FILL_W > POS_W) ? FILL_W : POS_W;

    // Request codes.
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_INSERT_AT  = 3'd4;
    localparam logic [FUNC_W-1:0] OP_REMOVE_AT  = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SEARCH     = 3'd6;

    // Per-cell commands.
    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_LOAD       = 2'd1;
    localparam logic [1:0] CELL_FROM_LEFT  = 2'd2;
    localparam logic [1:0] CELL_FROM_RIGHT = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } idq_in_t;

    typedef struct packed {
        logic               failed;
        logic               found;
        logic [COUNT_W-1:0] count;
    } idq_out_t;

    // Command and broadcast operand for one cell: data is the value to load,
    // and also the search key.
    typedef struct packed {
        logic [1:0]         cmd;
        logic [VALUE_W-1:0] data;
    } idq_cell_ctl_t;

endpackage

@@ rtl/idq_cell.sv @@
// ----------------------------------------------------------------------------
// idq_cell
// One storage cell of the deque row: holds a value, loads the broadcast
// operand or takes a neighbour's value, and flags a match with the operand.
// ----------------------------------------------------------------------------
module idq_cell
    import idq_pkg::*;
(
    input  logic                 aclk,
    input  idq_cell_ctl_t        ctl,
    input  logic [VALUE_W-1:0]   left_value,
    input  logic [VALUE_W-1:0]   right_value,
    output logic [VALUE_W-1:0]   value,
    output logic                 match
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    always_comb begin
        unique case (ctl.cmd)
            CELL_HOLD:       value_next = value_reg;
            CELL_LOAD:       value_next = ctl.data;
            CELL_FROM_LEFT:  value_next = left_value;
            CELL_FROM_RIGHT: value_next = right_value;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == ctl.data);

endmodule

@@ rtl/indexed_deque.sv @@
// ----------------------------------------------------------------------------
// indexed_deque
// Bounded ordered sequence of signed 32-bit values held in a row of cells,
// with push/pop at both ends, insert and remove at a position, and search.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+------------------------------------
//  s_      | in  | s_valid / s_ready  | s_data  : func, value, position
//  m_      | out | m_valid / m_ready  | m_data  : failed, found, count
//
//  One transaction per cycle while the output register can take a result:
//  every cell shifts, loads or compares in the cycle of acceptance, and the
//  result is registered into the output register on acceptance.
//  s_ready is high while the output register is empty or being drained, so
//  a new request is taken as the previous result drains, not while it waits.
//  Synchronous active-low reset clears the fill count and the output valid;
//  cell contents are left undefined and never read above the fill level.
//
module indexed_deque
    import idq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  idq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output idq_out_t m_data
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    idq_out_t          m_data_reg;
    idq_out_t          m_data_next;

    logic take;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] fill_ext;
    logic [IDX_W-1:0] pos_ext;
    logic [IDX_W-1:0] edit_pos;
    logic             full;
    logic             empty;
    logic             ok;
    logic             grow;      // open a gap at edit_pos
    logic             shrink;    // close the gap at edit_pos
    logic             drop_back; // pop back: count only
    logic             is_search;
    logic             found;

    logic [VALUE_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]   cell_match;
    logic [DEPTH-1:0]   cell_live;
    idq_cell_ctl_t      cell_ctl   [DEPTH];

    assign take    = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    assign fill_ext = IDX_W'(fill_reg);
    assign pos_ext  = IDX_W'(s_data.position);
    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign empty    = (fill_reg == '0);

    always_comb begin
        ok        = 1'b0;
        grow      = 1'b0;
        shrink    = 1'b0;
        drop_back = 1'b0;
        is_search = 1'b0;
        edit_pos  = '0;
        unique case (s_data.func)
            OP_PUSH_FRONT: begin
                ok   = !full;
                grow = 1'b1;
            end
            OP_PUSH_BACK: begin
                ok       = !full;
                grow     = 1'b1;
                edit_pos = fill_ext;
            end
            OP_POP_FRONT: begin
                ok     = !empty;
                shrink = 1'b1;
            end
            OP_POP_BACK: begin
                ok        = !empty;
                drop_back = 1'b1;
            end
            OP_INSERT_AT: begin
                // insert before an existing entry, or at the front
                ok       = !full && ((pos_ext == '0) || (pos_ext < fill_ext));
                grow     = 1'b1;
                edit_pos = pos_ext;
            end
            OP_REMOVE_AT: begin
                ok       = (pos_ext < fill_ext);
                shrink   = 1'b1;
                edit_pos = pos_ext;
            end
            OP_SEARCH: begin
                ok        = 1'b1;
                is_search = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Cell row: each cell decides hold / load / shift from its index
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VALUE_W-1:0] left_v;
            logic [VALUE_W-1:0] right_v;

            always_comb begin
                cell_ctl[gi].data = s_data.value;
                cell_ctl[gi].cmd  = CELL_HOLD;
                if (take && ok && grow) begin
                    if (IDX_W'(gi) == edit_pos) begin
                        cell_ctl[gi].cmd = CELL_LOAD;
                    end else if (IDX_W'(gi) > edit_pos) begin
                        cell_ctl[gi].cmd = CELL_FROM_LEFT;
                    end
                end else if (take && ok && shrink) begin
                    if (IDX_W'(gi) >= edit_pos) begin
                        cell_ctl[gi].cmd = CELL_FROM_RIGHT;
                    end
                end
            end

            // End cells take their own or the operand at the open edge; cell 0 never
            // selects its left input, and the last cell's right input is its own value.
            if (gi == 0) begin : g_left_end
                assign left_v = s_data.value;
            end else begin : g_left
                assign left_v = cell_value[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_right_end
                assign right_v = cell_value[gi];
            end else begin : g_right
                assign right_v = cell_value[gi+1];
            end

            // Only entries below the fill level take part in a search.
            assign cell_live[gi] = (IDX_W'(gi) < fill_ext);

            idq_cell u_cell (
                .aclk        (aclk),
                .ctl         (cell_ctl[gi]),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (cell_value[gi]),
                .match       (cell_match[gi])
            );
        end
    endgenerate

    assign found = is_search && |(cell_match & cell_live);

    // ------------------------------------------------------------------
    // Fill count and result
    // ------------------------------------------------------------------
    always_comb begin
        logic [FILL_W+COUNT_W-1:0] count_wide;
        fill_next = fill_reg;
        if (take && ok) begin
            if (grow) begin
                fill_next = fill_reg + FILL_W'(1);
            end else if (shrink || drop_back) begin
                fill_next = fill_reg - FILL_W'(1);
            end
        end
        count_wide = {{COUNT_W{1'b0}}, fill_next};
        m_data_next.failed = !ok;
        m_data_next.found  = found;
        m_data_next.count  = count_wide[COUNT_W-1:0];
    end

    // Load a fresh result on acceptance, drop it once taken downstream.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: hold unless a new transaction is accepted.
    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ bench/indexed_deque_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_tb
// Self-checking bench for the indexed deque: drives requests through the
// s_ channel with bursty pacing, keeps a shadow copy of the stored sequence
// to work out each result, and compares every m_ transaction field by field.
// ----------------------------------------------------------------------------
module indexed_deque_tb;
    import idq_pkg::*;

    // No request code exists for the last encoding; the block must reject it.
    localparam logic [FUNC_W-1:0] OP_UNDEFINED = 3'd7;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_GAP     = 12;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    idq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    idq_out_t m_data;

    indexed_deque dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Shadow of the stored sequence: entry 0 is the front.
    logic signed [VALUE_W-1:0] shadow_cells [DEPTH];
    int                        shadow_fill = 0;
    idq_out_t                  pending_results [$];
    int                        mismatches = 0;

    // Sender pacing and receiver hold-off hand-over.
    int burst_left    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int stall_cycles  = 0;

    // ------------------------------------------------------------------------
    // Shadow sequence: shift up from pos and load, or shift down onto pos.
    // ------------------------------------------------------------------------
    function automatic void open_slot(int pos, logic signed [VALUE_W-1:0] v);
        for (int i = shadow_fill; i > pos; i--)
            shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[pos] = v;
        shadow_fill++;
    endfunction

    function automatic void close_slot(int pos);
        for (int i = pos; i + 1 < shadow_fill; i++)
            shadow_cells[i] = shadow_cells[i+1];
        shadow_fill--;
    endfunction

    // Apply one request to the shadow and return the result it must produce.
    function automatic idq_out_t deque_apply(idq_in_t req);
        idq_out_t res;
        logic     fail;
        logic     hit;
        int       pos;
        fail = 1'b0;
        hit  = 1'b0;
        pos  = int'(req.position);
        case (req.func)
            OP_PUSH_FRONT: begin
                if (shadow_fill >= DEPTH) fail = 1'b1;
                else open_slot(0, req.value);
            end
            OP_PUSH_BACK: begin
                if (shadow_fill >= DEPTH) fail = 1'b1;
                else open_slot(shadow_fill, req.value);
            end
            OP_POP_FRONT: begin
                if (shadow_fill == 0) fail = 1'b1;
                else close_slot(0);
            end
            OP_POP_BACK: begin
                if (shadow_fill == 0) fail = 1'b1;
                else shadow_fill--;
            end
            OP_INSERT_AT: begin
                // Position 0 goes unless full; any other must already exist.
                if (shadow_fill >= DEPTH || (pos != 0 && pos >= shadow_fill)) fail = 1'b1;
                else open_slot(pos, req.value);
            end
            OP_REMOVE_AT: begin
                if (pos >= shadow_fill) fail = 1'b1;
                else close_slot(pos);
            end
            OP_SEARCH: begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_cells[i] == req.value) hit = 1'b1;
            end
            default: fail = 1'b1;
        endcase
        res.failed = fail;
        res.found  = hit;
        res.count  = COUNT_W'(shadow_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Offer one request and hold it until the transaction completes. Idle
    // gaps fall between bursts; valid is only lowered when a gap follows.
    // ------------------------------------------------------------------------
    task automatic send_req(input logic [FUNC_W-1:0] func,
                            input logic signed [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position);
        idq_in_t req;
        int      gap;
        req.func     = func;
        req.value    = value;
        req.position = position;
        if (burst_left == 0) begin
            gap = $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // Now and then a long burst, so stretches with no idling occur.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(deque_apply(req));
        burst_left--;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh0000_0000;
                    1: return 32'sh0000_0001;
                    2: return 32'shFFFF_FFFF;
                    3: return 32'sh8000_0000;
                    default: return 32'sh7FFF_FFFF;
                endcase
            end
            3: return $urandom_range(0, 7);
            default: begin
                // Reuse a stored value so searches hit.
                if (shadow_fill > 0) return shadow_cells[$urandom_range(0, shadow_fill - 1)];
                return $urandom();
            end
        endcase
    endfunction

    // One random request; grow_pct sets the share of adds among adds/removes.
    task automatic send_random(input int grow_pct);
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            func = OP_UNDEFINED;
        else if (roll < 16)
            func = OP_SEARCH;
        else if ($urandom_range(0, 99) < grow_pct)
            case ($urandom_range(0, 2))
                0: func = OP_PUSH_FRONT;
                1: func = OP_PUSH_BACK;
                default: func = OP_INSERT_AT;
            endcase
        else
            case ($urandom_range(0, 2))
                0: func = OP_POP_FRONT;
                1: func = OP_POP_BACK;
                default: func = OP_REMOVE_AT;
            endcase
        // Mostly positions around the fill level, boundary included.
        if ($urandom_range(0, 3) == 0)
            pos = POS_W'($urandom_range(0, 15));
        else
            pos = POS_W'($urandom_range(0, (shadow_fill > 15) ? 15 : shadow_fill));
        send_req(func, pick_value(), pos);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_store();
        send_req(OP_POP_FRONT, 32'sh0, 4'd0);
        send_req(OP_POP_BACK,  32'sh0, 4'd0);
        send_req(OP_REMOVE_AT, 32'sh0, 4'd0);
        send_req(OP_REMOVE_AT, 32'sh0, 4'd15);
        send_req(OP_SEARCH,    32'sh0, 4'd0);
        send_req(OP_UNDEFINED, 32'shFFFF_FFFF, 4'd15);
        send_req(OP_INSERT_AT, 32'sh5, 4'd1);
        send_req(OP_INSERT_AT, 32'sh5, 4'd15);
    endtask

    task automatic test_extremes();
        send_req(OP_PUSH_BACK,  32'sh7FFF_FFFF, 4'd0);
        send_req(OP_PUSH_FRONT, 32'sh8000_0000, 4'd0);
        send_req(OP_INSERT_AT,  32'sh1234_5678, 4'd2);   // append: rejected
        send_req(OP_INSERT_AT,  32'sh0,         4'd1);
        send_req(OP_INSERT_AT,  32'shFFFF_FFFF, 4'd0);
        send_req(OP_SEARCH,     32'sh8000_0000, 4'd0);
        send_req(OP_SEARCH,     32'sh7FFF_FFFF, 4'd15);
        send_req(OP_SEARCH,     32'sh1,         4'd0);
        send_req(OP_REMOVE_AT,  32'sh0,         4'd4);   // past the back
        send_req(OP_REMOVE_AT,  32'sh0,         4'd3);   // the back itself
        send_req(OP_SEARCH,     32'sh7FFF_FFFF, 4'd0);
        send_req(OP_POP_FRONT,  32'sh0,         4'd0);
        send_req(OP_POP_BACK,   32'sh0,         4'd0);
        send_req(OP_PUSH_BACK,  32'sh5555_5555, 4'd15);
        send_req(OP_UNDEFINED,  32'sh0,         4'd0);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_random(50);
    endtask

    // Drive to full and hammer it, then drain to empty and hammer that.
    task automatic test_fill_drain(input int rounds);
        repeat (rounds) begin
            while (shadow_fill < DEPTH) send_random(85);
            repeat (6) send_random(85);
            while (shadow_fill > 0) send_random(15);
            repeat (6) send_random(15);
        end
    endtask

    // Hold the receiver off while requests keep coming, so the output
    // register fills and s_ready drops.
    task automatic test_backpressure(input int n);
        hold_requests++;
        burst_left = n;
        repeat (n) send_random(50);
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: its own pattern of stalls, plus a long hold-off on
    // request.
    // ------------------------------------------------------------------------
    int         hold_left = 0;
    int         mode_left = 0;
    int         sink_mode = 0;
    logic [7:0] sink_mask = 8'hFF;

    always @(posedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
            sink_mask = 8'($urandom());
        end
        mode_left--;
        sink_mask = {sink_mask[6:0], sink_mask[7]};
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (sink_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= sink_mask[0];
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each result transaction with the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        idq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.failed !== want.failed) begin
                    $display("%0t: failed mismatch, expected %0b, actual %0b",
                             $time, want.failed, m_data.failed);
                    mismatches++;
                end
                if (m_data.found !== want.found) begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, m_data.found);
                    mismatches++;
                end
                if (m_data.count !== want.count) begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, want.count, m_data.count);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_store();
        test_extremes();
        test_random_mix(700);
        test_fill_drain(10);
        test_backpressure(60);
        test_random_mix(270);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // Allow a stray result to show up before judging.
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
